/* sv/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, codes and defaults of the shortest path with route unit.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 512;
   localparam int DEF_COST_BITS = 16;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] ST_ROUTE   = 2'd0;
   localparam logic [1:0] ST_UNREACH = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [21:0] DIST_MAX = 22'h3FFFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  edge_from;
      logic [5:0]  edge_to;
      logic [15:0] edge_cost;
      logic [5:0]  source_node;
      logic [5:0]  target_node;
   } req_type;

   typedef struct packed {
      logic [5:0]  route_node;
      logic [21:0] route_distance;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // distance memory read address source
   typedef enum logic [1:0] {
      DSEL_SCAN = 2'd0,
      DSEL_EDGE = 2'd1,
      DSEL_DST  = 2'd2
   } dsel_type;

   typedef struct packed {
      logic     clear_edges;
      logic     add_edge;
      logic     start_query;
      logic     scan_start;
      logic     scan_step;
      logic     settle;
      logic     edge_next;
      logic     relax;
      dsel_type dist_sel;
      logic     walk_start;
      logic     walk_write;
      logic     walk_step;
      logic     emit_route;
      logic     emit_unreach;
      logic     emit_full;
   } cmd_type;

   typedef struct packed {
      logic req_bad;
      logic edges_full;
      logic scan_done;
      logic found;
      logic edges_done;
      logic edge_match;
      logic dst_settled;
      logic walk_end;
      logic emit_last;
      logic out_free;
   } stat_type;

endpackage

/* sv/spr_ctrl.sv */
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer of the unit: table updates, search, route walk and word emission.
// ----------------------------------------------------------------------------
module spr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  spr_pkg::stat_type stat,
   output spr_pkg::cmd_type  cmd
);

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_FULL    = 14'b00000000000010,
      S_UNREACH = 14'b00000000000100,
      S_SCAN    = 14'b00000000001000,
      S_PICK    = 14'b00000000010000,
      S_ERD     = 14'b00000000100000,
      S_EDW     = 14'b00000001000000,
      S_ECMP    = 14'b00000010000000,
      S_TDIST   = 14'b00000100000000,
      S_TCAP    = 14'b00001000000000,
      S_WALK    = 14'b00010000000000,
      S_WWAIT   = 14'b00100000000000,
      S_EADDR   = 14'b01000000000000,
      S_ESEND   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.dist_sel = spr_pkg::DSEL_SCAN;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_action)
                  spr_pkg::ACT_CLEAR: cmd.clear_edges = 1'b1;
                  spr_pkg::ACT_ADD: begin
                     if (stat.edges_full) begin
                        state_in = S_FULL;
                     end else begin
                        cmd.add_edge = 1'b1;
                     end
                  end
                  spr_pkg::ACT_QUERY: begin
                     if (stat.req_bad) begin
                        state_in = S_UNREACH;
                     end else begin
                        cmd.start_query = 1'b1;
                        cmd.scan_start  = 1'b1;
                        state_in        = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FULL: begin
            if (stat.out_free) begin
               cmd.emit_full = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_UNREACH: begin
            if (stat.out_free) begin
               cmd.emit_unreach = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_PICK;
         end
         S_PICK: begin
            if (stat.found) begin
               cmd.settle = 1'b1;
               state_in   = S_ERD;
            end else if (stat.dst_settled) begin
               state_in = S_TDIST;
            end else begin
               state_in = S_UNREACH;
            end
         end
         S_ERD: begin
            if (stat.edges_done) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_EDW;
            end
         end
         S_EDW: begin
            cmd.dist_sel = spr_pkg::DSEL_EDGE;
            if (stat.edge_match) begin
               state_in = S_ECMP;
            end else begin
               cmd.edge_next = 1'b1;
               state_in      = S_ERD;
            end
         end
         S_ECMP: begin
            cmd.relax     = 1'b1;
            cmd.edge_next = 1'b1;
            state_in      = S_ERD;
         end
         S_TDIST: begin
            cmd.dist_sel = spr_pkg::DSEL_DST;
            state_in     = S_TCAP;
         end
         S_TCAP: begin
            cmd.walk_start = 1'b1;
            state_in       = S_WALK;
         end
         S_WALK: begin
            cmd.walk_write = 1'b1;
            state_in       = stat.walk_end ? S_EADDR : S_WWAIT;
         end
         S_WWAIT: begin
            cmd.walk_step = 1'b1;
            state_in      = S_WALK;
         end
         S_EADDR: state_in = S_ESEND;
         S_ESEND: begin
            if (stat.out_free) begin
               cmd.emit_route = 1'b1;
               state_in       = stat.emit_last ? S_IDLE : S_EADDR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* sv/spr_datapath.sv */
// ----------------------------------------------------------------------------
// spr_datapath
// Edge table, node memories, search counters and the result word register.
// ----------------------------------------------------------------------------
module spr_datapath #(
   parameter int MAX_NODES = spr_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = spr_pkg::DEF_MAX_EDGES,
   parameter int COST_BITS = spr_pkg::DEF_COST_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  spr_pkg::req_type  req_word,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output spr_pkg::rsp_type  rsp_word,
   input  spr_pkg::cmd_type  cmd,
   output spr_pkg::stat_type stat
);

   localparam int NIW = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int DW  = COST_BITS + NIW;
   localparam int EDW = 12 + COST_BITS;

   // edge entry: origin, destination, cost
   logic [EDW-1:0] edge_mem [MAX_EDGES];
   logic [EDW-1:0] edge_rd_ff;
   logic [DW-1:0]  dist_mem [MAX_NODES];
   logic [DW-1:0]  dist_rd_ff;
   logic [NIW-1:0] pred_mem [MAX_NODES];
   logic [NIW-1:0] pred_rd_ff;
   logic [NIW-1:0] route_mem [MAX_NODES];
   logic [NIW-1:0] route_rd_ff;

   logic [ECW-1:0] edge_total_ff;
   logic [ECW-1:0] ecnt_ff;
   logic [NIW-1:0] src_ff, dst_ff;
   logic [MAX_NODES-1:0] reached_ff, settled_ff;
   logic [NCW-1:0] scan_ff;
   logic [NIW-1:0] tag_ff;
   logic           tag_vld_ff;
   logic           found_ff;
   logic [NIW-1:0] best_ff;
   logic [DW-1:0]  best_dist_ff;
   logic [DW-1:0]  total_ff;
   logic [NCW-1:0] len_ff;
   logic [NIW-1:0] v_ff;
   logic           rsp_valid_ff;
   spr_pkg::rsp_type rsp_ff;

   logic [5:0]           e_from, e_to;
   logic [COST_BITS-1:0] e_cost;
   logic [NIW-1:0]       e_to_idx;
   logic [DW-1:0]        nd;
   logic                 improve;
   logic [NIW-1:0]       dist_addr;
   logic [NIW-1:0]       q_src, q_dst;
   logic [NCW-1:0]       len_dec;
   logic                 cand;

   assign e_from   = edge_rd_ff[EDW-1 -: 6];
   assign e_to     = edge_rd_ff[COST_BITS +: 6];
   assign e_cost   = edge_rd_ff[COST_BITS-1:0];
   assign e_to_idx = NIW'(e_to);
   assign nd       = best_dist_ff + DW'(e_cost);
   assign improve  = !reached_ff[e_to_idx] || (dist_rd_ff > nd);
   assign q_src    = NIW'(req_word.source_node);
   assign q_dst    = NIW'(req_word.target_node);
   assign len_dec  = len_ff - NCW'(1);
   assign cand     = tag_vld_ff && reached_ff[tag_ff] && !settled_ff[tag_ff] &&
                     (!found_ff || dist_rd_ff < best_dist_ff);

   always_comb begin
      case (cmd.dist_sel)
         spr_pkg::DSEL_EDGE: dist_addr = e_to_idx;
         spr_pkg::DSEL_DST:  dist_addr = dst_ff;
         default:            dist_addr = scan_ff[NIW-1:0];
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.add_edge) begin
         edge_mem[edge_total_ff[EIW-1:0]] <=
            {req_word.edge_from, req_word.edge_to, COST_BITS'(req_word.edge_cost)};
      end
      edge_rd_ff <= edge_mem[ecnt_ff[EIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         dist_mem[q_src] <= '0;
      end else if (cmd.relax && improve) begin
         dist_mem[e_to_idx] <= nd;
      end
      dist_rd_ff <= dist_mem[dist_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         pred_mem[q_src] <= q_src;
      end else if (cmd.relax && improve) begin
         pred_mem[e_to_idx] <= best_ff;
      end
      pred_rd_ff <= pred_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_write) begin
         route_mem[len_ff[NIW-1:0]] <= v_ff;
      end
      route_rd_ff <= route_mem[len_dec[NIW-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_edges) begin
            edge_total_ff <= '0;
         end else if (cmd.add_edge) begin
            edge_total_ff <= edge_total_ff + ECW'(1);
         end
         if (cmd.emit_route || cmd.emit_unreach || cmd.emit_full) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // search state
   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         src_ff     <= q_src;
         dst_ff     <= q_dst;
         reached_ff <= {{(MAX_NODES-1){1'b0}}, 1'b1} << q_src;
         settled_ff <= '0;
      end else begin
         if (cmd.settle) settled_ff[best_ff] <= 1'b1;
         if (cmd.relax && improve) reached_ff[e_to_idx] <= 1'b1;
      end

      if (cmd.scan_start) begin
         scan_ff    <= '0;
         tag_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.scan_step) begin
         if (32'(scan_ff) < MAX_NODES) begin
            scan_ff    <= scan_ff + NCW'(1);
            tag_ff     <= scan_ff[NIW-1:0];
            tag_vld_ff <= 1'b1;
         end else begin
            tag_vld_ff <= 1'b0;
         end
         if (cand) begin
            found_ff     <= 1'b1;
            best_ff      <= tag_ff;
            best_dist_ff <= dist_rd_ff;
         end
      end

      if (cmd.settle) begin
         ecnt_ff <= '0;
      end else if (cmd.edge_next) begin
         ecnt_ff <= ecnt_ff + ECW'(1);
      end

      if (cmd.walk_start) begin
         total_ff <= dist_rd_ff;
         len_ff   <= '0;
         v_ff     <= dst_ff;
      end else begin
         if (cmd.walk_write) len_ff <= len_ff + NCW'(1);
         if (cmd.walk_step)  v_ff   <= pred_rd_ff;
         if (cmd.emit_route) len_ff <= len_dec;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.emit_route) begin
         rsp_ff.route_node     <= 6'(route_rd_ff);
         rsp_ff.route_distance <= (64'(total_ff) > 64'(spr_pkg::DIST_MAX)) ?
                                  spr_pkg::DIST_MAX : 22'(total_ff);
         rsp_ff.status         <= spr_pkg::ST_ROUTE;
         rsp_ff.last           <= (len_ff == NCW'(1));
      end else if (cmd.emit_unreach || cmd.emit_full) begin
         rsp_ff.route_node     <= '0;
         rsp_ff.route_distance <= '0;
         rsp_ff.status         <= cmd.emit_full ? spr_pkg::ST_FULL : spr_pkg::ST_UNREACH;
         rsp_ff.last           <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign stat.req_bad     = (32'(req_word.source_node) >= MAX_NODES) ||
                             (32'(req_word.target_node) >= MAX_NODES);
   assign stat.edges_full  = (32'(edge_total_ff) >= MAX_EDGES);
   assign stat.scan_done   = (32'(scan_ff) >= MAX_NODES) && !tag_vld_ff;
   assign stat.found       = found_ff;
   assign stat.edges_done  = (ecnt_ff == edge_total_ff);
   assign stat.edge_match  = (32'(e_from) == 32'(best_ff)) && (32'(e_to) < MAX_NODES);
   assign stat.dst_settled = settled_ff[dst_ff];
   assign stat.walk_end    = (v_ff == src_ff) || (32'(len_ff) + 1 >= MAX_NODES);
   assign stat.emit_last   = (len_ff == NCW'(1));
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

/* sv/shortest_path_with_route_unit.sv */
// ----------------------------------------------------------------------------
// shortest_path_with_route_unit
// Directed edge table with shortest route search from a source to a target.
// ----------------------------------------------------------------------------
// usage:
//   req channel takes one word: clear (empties the edge table), add (appends
//   one edge) or query (source and target). rsp channel returns result words.
//   an add into a full table gives one word with status table full. a query
//   gives the route from source to target, one word per node, each with the
//   total distance and last on the final word, or one word with status
//   unreachable.
//   query steps: per settled node a scan of the distance memory and the
//   pick plus a pass over the edge table (an edge leaving the settled node
//   also takes a compare step), one final scan, a fetch of the target
//   distance, then the walk back over the route nodes and the emission of
//   the route words. the single read port of the distance memory and of the
//   edge memory shape these steps.
//   req_ready is high only between items; a word waiting in the output
//   register does not block the next item, but emission stalls while the
//   receiver holds rsp_ready low.
//   reset empties the edge table and drops any pending result.
// ----------------------------------------------------------------------------
module shortest_path_with_route_unit #(
   parameter int MAX_NODES = spr_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = spr_pkg::DEF_MAX_EDGES,
   parameter int COST_BITS = spr_pkg::DEF_COST_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  spr_pkg::req_type req_word,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output spr_pkg::rsp_type rsp_word
);

   spr_pkg::cmd_type  cmd;
   spr_pkg::stat_type stat;

   spr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_word.action),
      .stat       (stat),
      .cmd        (cmd)
   );

   spr_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES),
      .COST_BITS (COST_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

/* sv/spr_checker.sv */
// ----------------------------------------------------------------------------
// spr_checker
// Port level checks of the shortest path with route unit.
// ----------------------------------------------------------------------------
module spr_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input spr_pkg::rsp_type rsp_word
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != spr_pkg::ST_ROUTE |-> rsp_word.last)
      else $error("status word without last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != spr_pkg::ST_ROUTE |->
      rsp_word.route_node == '0 && rsp_word.route_distance == '0)
      else $error("status word with nonzero fields");

   // no new item while a route is still being emitted
   a_route_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> !req_ready)
      else $error("input taken in the middle of a route");

endmodule

bind shortest_path_with_route_unit spr_checker u_spr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the shortest path with route unit.
// Drives clear, add and query words, computes the expected route words with
// its own shortest path search over a copy of the edge table, and compares
// every returned word against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = spr_pkg::DEF_MAX_NODES;
   localparam int EDGES = spr_pkg::DEF_MAX_EDGES;
   // unused action code, the unit ignores it
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   spr_pkg::req_type req_word;
   logic             rsp_valid;
   logic             rsp_ready;
   spr_pkg::rsp_type rsp_word;

   shortest_path_with_route_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // shadow edge table
   logic [5:0]  tab_from [EDGES];
   logic [5:0]  tab_to [EDGES];
   logic [15:0] tab_cost [EDGES];
   int          tab_count;

   spr_pkg::rsp_type route_queue[$];
   int      error_count;
   int      sent_words;
   int      got_words;
   int      query_count;
   int      full_count;
   int      unreach_count;
   int      burst_left;
   int      stall_mode;

   task automatic report_mismatch(input string what, input spr_pkg::rsp_type got,
                                  input spr_pkg::rsp_type want);
      error_count++;
      $display("mismatch %s: got node %0d dist %0d st %0d last %0d, %s %0d %0d %0d %0d",
               what, got.route_node, got.route_distance, got.status, got.last,
               "want", want.route_node, want.route_distance, want.status, want.last);
   endtask

   function automatic spr_pkg::rsp_type make_rsp(input logic [5:0] n, input logic [21:0] d,
                                                 input logic [1:0] s, input logic l);
      spr_pkg::rsp_type r;
      r.route_node = n;
      r.route_distance = d;
      r.status = s;
      r.last = l;
      return r;
   endfunction

   task automatic predict_route(input logic [5:0] src, input logic [5:0] dst);
      longint node_dist [NODES];
      int     pred [NODES];
      bit     seen [NODES];
      bit     done [NODES];
      int     path [$];
      int     best;
      int     v;
      longint nd;
      logic [21:0] outd;
      for (int i = 0; i < NODES; i++) begin
         seen[i] = 0;
         done[i] = 0;
         node_dist[i] = 0;
         pred[i] = 0;
      end
      seen[src] = 1;
      pred[src] = src;
      forever begin
         best = -1;
         for (int i = 0; i < NODES; i++)
            if (seen[i] && !done[i] && (best < 0 || node_dist[i] < node_dist[best]))
               best = i;
         if (best < 0)
            break;
         done[best] = 1;
         for (int e = 0; e < tab_count; e++) begin
            if (tab_from[e] != best)
               continue;
            nd = node_dist[best] + tab_cost[e];
            if (!seen[tab_to[e]] || node_dist[tab_to[e]] > nd) begin
               seen[tab_to[e]] = 1;
               node_dist[tab_to[e]] = nd;
               pred[tab_to[e]] = best;
            end
         end
      end
      if (!done[dst]) begin
         route_queue.push_back(make_rsp(6'd0, 22'd0, spr_pkg::ST_UNREACH, 1'b1));
         unreach_count++;
         return;
      end
      outd = (node_dist[dst] > spr_pkg::DIST_MAX) ? spr_pkg::DIST_MAX : node_dist[dst][21:0];
      v = dst;
      path.push_front(v);
      while (v != src && path.size() < NODES) begin
         v = pred[v];
         path.push_front(v);
      end
      foreach (path[i])
         route_queue.push_back(make_rsp(path[i][5:0], outd, spr_pkg::ST_ROUTE,
                                        i == path.size() - 1));
   endtask

   task automatic predict_word(input spr_pkg::req_type w);
      case (w.action)
         spr_pkg::ACT_CLEAR: tab_count = 0;
         spr_pkg::ACT_ADD: begin
            if (tab_count >= EDGES) begin
               route_queue.push_back(make_rsp(6'd0, 22'd0, spr_pkg::ST_FULL, 1'b1));
               full_count++;
            end else begin
               tab_from[tab_count] = w.edge_from;
               tab_to[tab_count] = w.edge_to;
               tab_cost[tab_count] = w.edge_cost;
               tab_count++;
            end
         end
         spr_pkg::ACT_QUERY: begin
            query_count++;
            predict_route(w.source_node, w.target_node);
         end
         default: ;
      endcase
   endtask

   // sends one word, with bursts and gaps
   task automatic send_word(input spr_pkg::req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_word(w);
      sent_words++;
   endtask

   function automatic spr_pkg::req_type make_req(input logic [1:0] a, input logic [5:0] f,
                                                 input logic [5:0] t, input logic [15:0] c,
                                                 input logic [5:0] s, input logic [5:0] d);
      spr_pkg::req_type r;
      r.action = a;
      r.edge_from = f;
      r.edge_to = t;
      r.edge_cost = c;
      r.source_node = s;
      r.target_node = d;
      return r;
   endfunction

   function automatic spr_pkg::req_type rand_req(input logic [1:0] a);
      spr_pkg::req_type r;
      r.action = a;
      r.edge_from = 6'($urandom);
      r.edge_to = 6'($urandom);
      r.edge_cost = 16'($urandom);
      r.source_node = 6'($urandom);
      r.target_node = 6'($urandom);
      return r;
   endfunction

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_words++;
         if (route_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_word, '0);
         end else begin
            if (rsp_word !== route_queue[0])
               report_mismatch("field", rsp_word, route_queue[0]);
            void'(route_queue.pop_front());
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic test_directed();
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd5, 6'd5));    // source is target
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd0, 6'd63));   // empty table
      send_word(make_req(spr_pkg::ACT_ADD, 6'd0, 6'd1, 16'd0, '0, '0));
      send_word(make_req(spr_pkg::ACT_ADD, 6'd1, 6'd63, 16'hFFFF, '0, '0));
      send_word(make_req(spr_pkg::ACT_ADD, 6'd0, 6'd63, 16'hFFFF, '0, '0));
      send_word(make_req(spr_pkg::ACT_ADD, 6'd0, 6'd2, 16'd3, '0, '0));
      send_word(make_req(spr_pkg::ACT_ADD, 6'd2, 6'd1, 16'd0, '0, '0));  // tie paths
      send_word(make_req(spr_pkg::ACT_ADD, 6'd63, 6'd0, 16'd1, '0, '0));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd0, 6'd63));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd63, 6'd2));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd1, 6'd2));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd10, 6'd0));   // unreachable
      send_word(make_req(ACT_IGNORED, 6'h3F, 6'h3F, 16'hFFFF, 6'h3F, 6'h3F));
      send_word(make_req(spr_pkg::ACT_CLEAR, '0, '0, '0, '0, '0));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd0, 6'd1));
   endtask

   // long chain through all nodes: longest route
   task automatic test_long_route();
      send_word(make_req(spr_pkg::ACT_CLEAR, '0, '0, '0, '0, '0));
      for (int i = 0; i < NODES - 1; i++)
         send_word(make_req(spr_pkg::ACT_ADD, i[5:0], 6'(i + 1), 16'hFFFF, '0, '0));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd0, 6'd63));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd63, 6'd0));
   endtask

   // fill the rest of the table to capacity and overflow it
   task automatic test_table_full();
      int fill;
      fill = EDGES - tab_count;
      for (int i = 0; i < fill; i++)
         send_word(make_req(spr_pkg::ACT_ADD, 6'($urandom_range(0, 7)),
                            6'($urandom_range(0, 7)), 16'($urandom), '0, '0));
      repeat (3)
         send_word(rand_req(spr_pkg::ACT_ADD));
      send_word(make_req(spr_pkg::ACT_QUERY, '0, '0, '0, 6'd0, 6'd7));
      send_word(make_req(spr_pkg::ACT_CLEAR, '0, '0, '0, '0, '0));
   endtask

   // random small graphs, then queries on them
   task automatic test_random_graphs();
      int n;
      int span;
      spr_pkg::req_type w;
      for (int g = 0; g < 4; g++) begin
         send_word(make_req(spr_pkg::ACT_CLEAR, '0, '0, '0, '0, '0));
         span = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(3, 15);
         n = $urandom_range(5, 20);
         for (int i = 0; i < n; i++) begin
            w = rand_req(spr_pkg::ACT_ADD);
            w.edge_from = 6'($urandom_range(0, span));
            w.edge_to = 6'($urandom_range(0, span));
            if ($urandom_range(0, 2) == 0)
               w.edge_cost = 16'($urandom_range(0, 4));
            send_word(w);
         end
         for (int q = 0; q < 6; q++) begin
            w = rand_req($urandom_range(0, 9) == 0 ? ACT_IGNORED : spr_pkg::ACT_QUERY);
            w.source_node = 6'($urandom_range(0, span));
            w.target_node = 6'($urandom_range(0, span));
            send_word(w);
         end
      end
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_ready = 1'b0;
      stall_mode = 0;
      burst_left = 0;
      tab_count = 0;
      error_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_graphs();
      test_long_route();
      test_table_full();
      req_valid <= 1'b0;
      waited = 0;
      while (route_queue.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (route_queue.size() != 0) begin
         error_count++;
         $display("%0d expected words never returned", route_queue.size());
      end
      $display("sent %0d words (%0d queries), checked %0d result words", sent_words,
               query_count, got_words);
      $display("covered %0d unreachable and %0d table full results", unreach_count,
               full_count);
      if (error_count == 0)
         $display("PASS shortest_path_with_route_unit");
      else
         $display("FAIL shortest_path_with_route_unit");
      $finish;
   end

   initial begin
      #400ms;
      $display("FAIL shortest_path_with_route_unit");
      $finish;
   end

endmodule
